/* rtl/core/cross_correlation_delay_detector_macros.svh */
// assertion macros used by the checker file
// depends on nothing; included by the checker module
`ifndef CROSS_CORRELATION_DELAY_DETECTOR_MACROS_SVH
`define CROSS_CORRELATION_DELAY_DETECTOR_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define CCDD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication checked outside reset
`define CCDD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

/* rtl/core/ccdd_pkg.sv */
// shared types, constants and codes for the delay detector
// depends on nothing
package ccdd_pkg;
   localparam int MaxWindow = 1024;
   localparam int AddrW     = $clog2(MaxWindow);
   localparam int CntW      = AddrW + 1;
   localparam int EnW       = 32 + CntW;
   localparam int AccW      = 32 + CntW;
   localparam int LagW      = 11;
   localparam int WideW     = 256;
   localparam int QDepth    = 4;
   localparam int QPtrW     = $clog2(QDepth);

   localparam logic [1:0] StFound   = 2'd0;
   localparam logic [1:0] StShort   = 2'd1;
   localparam logic [1:0] StSilent  = 2'd2;
   localparam logic [1:0] StWeak    = 2'd3;

   localparam logic [0:0] RegThr    = 1'b0;
   localparam logic [0:0] RegMinWin = 1'b1;

   typedef struct packed {
      logic signed [15:0] ref_sample;
      logic signed [15:0] meas_sample;
      logic               last;
   } req_type;

   typedef struct packed {
      logic signed [LagW-1:0] delay_samples;
      logic [1:0]             status;
   } rsp_type;

   // entry handed from front to back: close of one window
   typedef struct packed {
      logic [1:0]         kind;     // status if decided early, else StFound = search
      logic [CntW-1:0]    n;
      logic [EnW-1:0]     e_ref;
      logic [EnW-1:0]     e_meas;
      logic [14:0]        thr;
   } job_type;

   // control from back to front
   typedef struct packed {
      logic busy;   // back end not idle: lag search, threshold test or result
   } bctl_type;
endpackage

/* rtl/core/ccdd_ram.sv */
// generic single-write single-read ram, registered read
// depends on nothing
module ccdd_ram #(
   parameter int Width = 16,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end
   assign rdata = rdata_ff;
endmodule

/* rtl/core/ccdd_front.sv */
// front end: loads pairs, keeps count and energies, classifies a closed window
// depends on ccdd_pkg
module ccdd_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      acc,
   input  ccdd_pkg::req_type         req,
   input  logic [14:0]               thr,
   input  logic [10:0]               min_win,
   output logic                      we,
   output logic [ccdd_pkg::AddrW-1:0] waddr,
   output logic                      push,
   output ccdd_pkg::job_type         job
);
   logic [ccdd_pkg::CntW-1:0] cnt_ff, cnt_in;
   logic [ccdd_pkg::EnW-1:0]  er_ff, er_in, em_ff, em_in;
   logic [31:0]               sq_r, sq_m;
   logic                      room;

   assign room  = cnt_ff < ccdd_pkg::CntW'(ccdd_pkg::MaxWindow);
   assign we    = acc && room;
   assign waddr = cnt_ff[ccdd_pkg::AddrW-1:0];
   assign sq_r  = 32'($signed(req.ref_sample) * $signed(req.ref_sample));
   assign sq_m  = 32'($signed(req.meas_sample) * $signed(req.meas_sample));

   // window bookkeeping
   always_comb begin
      cnt_in = cnt_ff;
      er_in  = er_ff;
      em_in  = em_ff;
      if (we) begin
         cnt_in = cnt_ff + 1'b1;
         er_in  = er_ff + ccdd_pkg::EnW'(sq_r);
         em_in  = em_ff + ccdd_pkg::EnW'(sq_m);
      end
      job.n      = cnt_in;
      job.e_ref  = er_in;
      job.e_meas = em_in;
      job.thr    = thr;
      priority if (12'(cnt_in) < 12'(min_win)) begin
         job.kind = ccdd_pkg::StShort;
      end else if (er_in == '0 || em_in == '0) begin
         job.kind = ccdd_pkg::StSilent;
      end else begin
         job.kind = ccdd_pkg::StFound;
      end
      push = acc && req.last;
      if (push) begin
         cnt_in = '0;
         er_in  = '0;
         em_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         er_ff  <= '0;
         em_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         er_ff  <= er_in;
         em_ff  <= em_in;
      end
   end
endmodule

/* rtl/core/ccdd_queue.sv */
// short queue of closed windows between front and back
// depends on ccdd_pkg
module ccdd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ccdd_pkg::job_type din,
   input  logic              pop,
   output logic              empty,
   output ccdd_pkg::job_type dout
);
   ccdd_pkg::job_type            q_ff [ccdd_pkg::QDepth];
   logic [ccdd_pkg::QPtrW-1:0]   wp_ff, rp_ff;
   logic [ccdd_pkg::QPtrW:0]     cnt_ff;

   assign empty = cnt_ff == '0;
   assign dout  = q_ff[rp_ff];

   // pointer and count update
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop)  rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (ccdd_pkg::QPtrW+1)'(push) - (ccdd_pkg::QPtrW+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= din;
   end
endmodule

/* rtl/core/ccdd_back.sv */
// back end: lag search over the stored window, peak pick and threshold test
// depends on ccdd_pkg
module ccdd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   input  ccdd_pkg::job_type           job,
   output logic                        pop,
   output logic [ccdd_pkg::AddrW-1:0]  raddr_r,
   output logic [ccdd_pkg::AddrW-1:0]  raddr_m,
   input  logic signed [15:0]          rd_r,
   input  logic signed [15:0]          rd_m,
   output ccdd_pkg::bctl_type          ctl,
   output logic                        rsp_valid,
   output ccdd_pkg::rsp_type           rsp
);
   localparam int CW = ccdd_pkg::CntW;
   localparam int AW = ccdd_pkg::AccW;
   localparam int WW = ccdd_pkg::WideW;

   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001,
      S_LAG  = 8'b00000010,
      S_MAC  = 8'b00000100,
      S_CMP  = 8'b00001000,
      S_THR  = 8'b00010000,
      S_MUL  = 8'b00100000,
      S_DEC  = 8'b01000000,
      S_OUT  = 8'b10000000
   } st_type;

   st_type                  st_ff, st_in;
   ccdd_pkg::job_type       job_ff;
   logic signed [CW:0]      d_ff, half;
   logic [CW-1:0]           i_ff, lo, hi, m_len;
   logic [1:0]              pipe_ff;  // read latency tracker
   logic                    issue_ff;
   logic signed [AW-1:0]    c_ff, best_c_ff;
   logic [CW-1:0]           best_m_ff;
   logic signed [CW:0]      best_d_ff;
   logic signed [31:0]      prod;
   // multi-cycle wide multiplier: acc += 32 bit slice * 16 bit digit per step
   logic [WW-1:0]           lhs_ff, rhs_ff, mcand_ff, macc_ff;
   logic [63:0]             mplier_ff;
   logic [5:0]              step_ff;
   logic [3:0]              k_ff;
   logic [4:0]              mix;
   logic [47:0]             part_prod;
   logic [8:0]              part_sh;
   logic signed [2*AW+2:0]  xl, xr;

   assign half = $signed({2'b00, job_ff.n[CW-1:1]});
   assign lo   = (d_ff < 0) ? CW'(-d_ff) : '0;
   assign hi   = (d_ff > 0) ? CW'(job_ff.n - CW'(d_ff)) : job_ff.n;
   assign m_len = hi - lo;
   assign raddr_r = i_ff[ccdd_pkg::AddrW-1:0];
   assign raddr_m = ccdd_pkg::AddrW'($signed({1'b0, i_ff}) + d_ff);
   assign prod = rd_r * rd_m;
   assign xl   = c_ff * $signed({1'b0, best_m_ff});
   assign xr   = best_c_ff * $signed({1'b0, m_len});
   assign ctl.busy = st_ff != S_IDLE;
   assign pop = (st_ff == S_IDLE) && !q_empty;

   // partial product select: digit in mix[4:3], multiplicand slice in mix[2:0]
   assign mix       = 5'(step_ff - 6'd1);
   assign part_prod = mcand_ff[{mix[2:0], 5'b0} +: 32] * mplier_ff[{mix[4:3], 4'b0} +: 16];
   assign part_sh   = {1'b0, mix[2:0], 5'b0} + {3'b0, mix[4:3], 4'b0};

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE: if (!q_empty) st_in = (job.kind == ccdd_pkg::StFound) ? S_LAG : S_OUT;
         S_LAG:  st_in = S_MAC;
         S_MAC:  if (!issue_ff && pipe_ff == '0) st_in = S_CMP;
         S_CMP:  st_in = (d_ff == half) ? S_THR : S_LAG;
         S_THR:  st_in = (best_c_ff <= 0) ? S_OUT : S_MUL;
         S_MUL:  if (k_ff == 4'd11) st_in = S_DEC;
         S_DEC:  st_in = S_OUT;
         S_OUT:  st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   // sequencer and datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= S_IDLE;
         rsp_valid <= 1'b0;
         issue_ff  <= 1'b0;
         pipe_ff   <= '0;
      end else begin
         st_ff     <= st_in;
         rsp_valid <= 1'b0;
         pipe_ff   <= {pipe_ff[0], issue_ff};
         unique case (st_ff)
            S_IDLE: begin
               if (!q_empty) begin
                  job_ff    <= job;
                  d_ff      <= -$signed({2'b00, job.n[CW-1:1]});
                  best_c_ff <= '0;
                  best_m_ff <= '0;
                  best_d_ff <= '0;
                  rsp.status        <= job.kind;
                  rsp.delay_samples <= '0;
               end
            end
            S_LAG: begin
               i_ff     <= lo;
               c_ff     <= '0;
               issue_ff <= lo < hi;
            end
            S_MAC: begin
               if (issue_ff) begin
                  if (i_ff + 1'b1 >= hi) issue_ff <= 1'b0;
                  i_ff <= i_ff + 1'b1;
               end
               // read data arrives in the cycle after its address
               if (pipe_ff[0]) c_ff <= c_ff + AW'(prod);
            end
            S_CMP: begin
               if (best_m_ff == '0 || xl > xr) begin
                  best_c_ff <= c_ff;
                  best_m_ff <= m_len;
                  best_d_ff <= d_ff;
               end
               d_ff <= d_ff + 1'b1;
            end
            S_THR: begin
               k_ff    <= '0;
               step_ff <= '0;
               lhs_ff  <= WW'(1);
               rhs_ff  <= WW'(1);
               if (best_c_ff <= 0) rsp.status <= ccdd_pkg::StWeak;
            end
            S_MUL: begin
               // factor k multiplies lhs (k<5) or rhs (k>=5), 32 steps per factor
               if (step_ff == 6'd0) begin
                  mcand_ff <= (k_ff == 4'd0 || k_ff == 4'd5) ? WW'(1) : macc_ff;
                  macc_ff  <= '0;
                  unique case (k_ff)
                     4'd0, 4'd1: mplier_ff <= 64'(best_c_ff);
                     4'd2, 4'd3: mplier_ff <= 64'(job_ff.n);
                     4'd4:       mplier_ff <= 64'(32'd1 << 30);
                     4'd5, 4'd6: mplier_ff <= 64'(job_ff.thr);
                     4'd7, 4'd8: mplier_ff <= 64'(best_m_ff);
                     4'd9:       mplier_ff <= 64'(job_ff.e_ref);
                     default:    mplier_ff <= 64'(job_ff.e_meas);
                  endcase
                  step_ff <= 6'd1;
               end else begin
                  macc_ff <= macc_ff + (WW'(part_prod) << part_sh);
                  if (step_ff == 6'd32) begin
                     step_ff <= '0;
                     k_ff    <= k_ff + 1'b1;
                  end else begin
                     step_ff <= step_ff + 1'b1;
                  end
               end
               if (step_ff == 6'd0 && k_ff != '0) begin
                  if (k_ff <= 4'd5) lhs_ff <= macc_ff;
                  else              rhs_ff <= macc_ff;
               end
            end
            S_DEC: begin
               if (lhs_ff > rhs_ff) begin
                  rsp.status        <= ccdd_pkg::StFound;
                  rsp.delay_samples <= ccdd_pkg::LagW'(best_d_ff);
               end else begin
                  rsp.status <= ccdd_pkg::StWeak;
               end
            end
            S_OUT: rsp_valid <= 1'b1;
            default: ;
         endcase
      end
   end
endmodule

/* rtl/core/cross_correlation_delay_detector.sv */
// top level of the delay detector: csr port, front, queue, back and sample memories
// depends on ccdd_pkg, ccdd_front, ccdd_queue, ccdd_back, ccdd_ram
// a last pair with a search runs the single multiply-accumulate over both sample
// memories once per lag, then the threshold test
// throughput: one pair per cycle while loading and busy is low; busy is held during the search
// reset: synchronous, clears window count, energies, queue and sequencer;
// registers return to 9830 and 64. the receiver cannot stall results
module cross_correlation_delay_detector (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ccdd_pkg::req_type     req_data,
   output logic                  rsp_strobe,
   output ccdd_pkg::rsp_type     rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   logic [14:0]                  thr_ff;
   logic [10:0]                  minw_ff;
   logic                         acc, we, push, pop, q_empty, pend_ff;
   logic [ccdd_pkg::AddrW-1:0]   waddr, ra_r, ra_m;
   logic signed [15:0]           rd_r, rd_m;
   ccdd_pkg::job_type            job_f, job_q;
   ccdd_pkg::bctl_type           bctl;

   assign pready = 1'b1;
   assign busy   = pend_ff || bctl.busy || !q_empty;
   assign acc    = start && !busy;

   // csr write and read
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= 15'd9830;
         minw_ff <= 11'd64;
      end else if (psel && penable && pwrite) begin
         if (paddr[2] == ccdd_pkg::RegThr)    thr_ff  <= pwdata[14:0];
         if (paddr[2] == ccdd_pkg::RegMinWin) minw_ff <= pwdata[10:0];
      end
   end
   assign prdata = (paddr[2] == ccdd_pkg::RegThr) ? {17'd0, thr_ff} : {21'd0, minw_ff};

   // hold busy for the cycle after a last transfer
   always_ff @(posedge clock) begin
      if (reset) pend_ff <= 1'b0;
      else       pend_ff <= push;
   end

   ccdd_front u_front (
      .clock, .reset, .acc, .req(req_data), .thr(thr_ff), .min_win(minw_ff),
      .we, .waddr, .push, .job(job_f)
   );

   ccdd_queue u_queue (
      .clock, .reset, .push, .din(job_f), .pop, .empty(q_empty), .dout(job_q)
   );

   ccdd_ram #(.Width(16), .Depth(ccdd_pkg::MaxWindow)) u_ref_mem (
      .clock, .we, .waddr, .wdata(req_data.ref_sample), .raddr(ra_r), .rdata(rd_r)
   );

   ccdd_ram #(.Width(16), .Depth(ccdd_pkg::MaxWindow)) u_meas_mem (
      .clock, .we, .waddr, .wdata(req_data.meas_sample), .raddr(ra_m), .rdata(rd_m)
   );

   ccdd_back u_back (
      .clock, .reset, .q_empty, .job(job_q), .pop, .raddr_r(ra_r), .raddr_m(ra_m),
      .rd_r, .rd_m, .ctl(bctl), .rsp_valid(rsp_strobe), .rsp(rsp_data)
   );
endmodule

/* rtl/core/ccdd_checker.sv */
// port-level checker for the delay detector, bound to the top level
// depends on ccdd_pkg and cross_correlation_delay_detector_macros.svh
`include "cross_correlation_delay_detector_macros.svh"
module ccdd_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input ccdd_pkg::rsp_type rsp_data,
   input ccdd_pkg::req_type req_data
);
   `CCDD_ASSERT_IMP(a_delay_zero, clock, reset, rsp_strobe && rsp_data.status != ccdd_pkg::StFound, rsp_data.delay_samples == '0, "nonzero delay on rejected window")
   `CCDD_ASSERT_NEXT(a_last_busy, clock, reset, start && !busy && req_data.last, busy, "last transfer did not raise busy")
   `CCDD_ASSERT_NEXT(a_one_strobe, clock, reset, rsp_strobe, !rsp_strobe, "result strobe longer than a cycle")
   `CCDD_ASSERT_IMP(a_strobe_busy, clock, reset, rsp_strobe, $past(busy), "result without a search")
endmodule

bind cross_correlation_delay_detector ccdd_checker u_ccdd_checker (
   .clock, .reset, .start, .busy, .rsp_strobe, .rsp_data, .req_data
);
